/* sv/branch_target_buffer_lru_core_defines.svh */
// ----------------------------------------------------------------------------
// BTB LRU assertion macros
// Shared check macros for the branch target buffer core.
// ----------------------------------------------------------------------------
`ifndef BRANCH_TARGET_BUFFER_LRU_CORE_DEFINES_SVH
`define BRANCH_TARGET_BUFFER_LRU_CORE_DEFINES_SVH

// Check that a condition holds at every edge outside reset.
`define BTBL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define BTBL_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define BTBL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/btbl_pkg.sv */
// ----------------------------------------------------------------------------
// BTB LRU package
// Payload types, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package btbl_pkg;

  localparam int FIELD_W = 32;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] source_addr;
    logic [FIELD_W-1:0] target_addr;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] target_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic match_en;
    logic update_en;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;
    logic victim_found;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* sv/branch_target_buffer_lru_core.sv */
// ----------------------------------------------------------------------------
// Branch target buffer, fully associative, true LRU
// Lookup and insert of source/target pairs with valid-bit tracked entries.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------
//  input   | in_valid / in_ready / in_data  | cmd, source_addr, target_addr
//  result  | out_valid / out_ready / out_data | hit, target_out
//
//  An item passes through capture at the transfer, parallel tag and oldest-rank
//  compare, rank/store update with the target memory read, then result load;
//  out_valid rises and the next transfer can come the cycle after.
//  The registered read port of the target memory sets the last step. A result
//  waits in the output register; the next item is taken meanwhile and stalls
//  only at its own result load. Reset leaves all entries invalid, entry 0 oldest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "branch_target_buffer_lru_core_defines.svh"

module branch_target_buffer_lru_core #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btbl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btbl_pkg::out_item_t out_data
);
  import btbl_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  state_t     state;

  btbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  btbl_dpath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `BTBL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken in flight")
  `BTBL_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "pending result overwritten")
  `BTBL_ASSERT_ALWAYS(a_victim_exists, stat.victim_found, "no entry holds the oldest rank")
  `BTBL_ASSERT_SAME(a_load_in_finish, cmd.load_out, state == ST_FINISH, "result load outside finish")

endmodule

`default_nettype wire

/* sv/btbl_ctrl.sv */
// ----------------------------------------------------------------------------
// BTB LRU controller
// Sequences one item through match, update and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module btbl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  btbl_pkg::ctrl_stat_t stat,
  output logic                 in_ready,
  output btbl_pkg::ctrl_cmd_t  cmd,
  output btbl_pkg::state_t     state
);
  import btbl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        // hold until the output register can take the result
        if (!stat.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_MATCH:  cmd.match_en  = 1'b1;
      ST_UPDATE: cmd.update_en = 1'b1;
      ST_FINISH: cmd.load_out  = !stat.out_stall;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  assign state = state_r;

endmodule

`default_nettype wire

/* sv/btbl_dpath.sv */
// ----------------------------------------------------------------------------
// BTB LRU datapath
// Tag match array, recency ranks, target memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btbl_dpath #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  btbl_pkg::ctrl_cmd_t  cmd,
  input  btbl_pkg::in_item_t   in_data,
  input  logic                 out_ready,
  output btbl_pkg::ctrl_stat_t stat,
  output logic                 out_valid,
  output btbl_pkg::out_item_t  out_data
);
  import btbl_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [RW-1:0] RANK_OLD = RW'(ENTRIES - 1);

  logic                 cmd_r;
  logic [ADDR_BITS-1:0] src_r;
  logic [ADDR_BITS-1:0] tgt_r;
  logic                 hit_r;
  logic [IW-1:0]        sel_r;
  logic [RW-1:0]        age_r;
  logic [RW-1:0]        rank_r  [ENTRIES];
  logic [ENTRIES-1:0]   valid_r;
  logic [ADDR_BITS-1:0] tag_r   [ENTRIES];
  logic [ADDR_BITS-1:0] tgt_mem [ENTRIES];
  logic [ADDR_BITS-1:0] rd_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [63:0]          src_ext;
  logic [63:0]          tgt_ext;
  logic [63:0]          rd_ext;
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   oldest;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        old_idx;
  logic [RW-1:0]        hit_age;
  logic                 touch;
  logic                 fill;

  assign src_ext = 64'(in_data.source_addr);
  assign tgt_ext = 64'(in_data.target_addr);
  assign rd_ext  = 64'(rd_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_data.cmd;
      src_r <= src_ext[ADDR_BITS-1:0];
      tgt_r <= tgt_ext[ADDR_BITS-1:0];
    end
  end

  // Valid tags are unique, so at most one entry matches; ranks are a
  // permutation, so exactly one entry holds the oldest rank.
  always_comb begin
    hit_idx = '0;
    old_idx = '0;
    hit_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (tag_r[i] == src_r);
      oldest[i] = (rank_r[i] == RANK_OLD);
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
        hit_age = hit_age | rank_r[i];
      end
      if (oldest[i]) begin
        old_idx = old_idx | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      hit_r <= |match;
      sel_r <= (|match) ? hit_idx : old_idx;
      age_r <= (|match) ? hit_age : RANK_OLD;
    end
  end

  assign touch = hit_r || (cmd_r == CMD_INSERT);
  assign fill  = (cmd_r == CMD_INSERT) && !hit_r;

  // Ranks: advance every entry younger than the touched one, zero the touched one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= RW'(ENTRIES - 1 - i);
      end
      valid_r <= '0;
    end else if (cmd.update_en && touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == sel_r) begin
          rank_r[i] <= '0;
        end else if (rank_r[i] < age_r) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
      if (fill) begin
        valid_r[sel_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en && fill) begin
      tag_r[sel_r] <= src_r;
    end
  end

  // Target memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.update_en && fill) begin
      tgt_mem[sel_r] <= tgt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      rd_r <= tgt_mem[sel_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.hit        <= hit_r;
      out_data_r.target_out <= ((cmd_r == CMD_LOOKUP) && hit_r) ? rd_ext[FIELD_W-1:0]
                                                                 : '0;
    end
  end

  assign stat.out_stall    = out_valid_r && !out_ready;
  assign stat.victim_found = |oldest;
  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;

endmodule

`default_nettype wire

/* sim/tb_branch_target_buffer_lru_core.sv */
// ----------------------------------------------------------------------------
// Branch target buffer LRU core testbench
// Drives lookups and inserts through the valid/ready input channel. A local
// model of the tag, target, valid and recency state predicts each result,
// and every result is checked in order against it. Directed tests cover cold
// misses, the fill order, refresh of a present address and LRU eviction.
// Random working sets of varied size then exercise hits, near misses and
// thrashing, with random stalls on both channels outside a final steady stream.
// ----------------------------------------------------------------------------
module tb_branch_target_buffer_lru_core;
  import btbl_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Shadow of the buffer state
  logic [FIELD_W-1:0] shadow_tag    [ENTRIES];
  logic [FIELD_W-1:0] shadow_target [ENTRIES];
  logic               shadow_valid  [ENTRIES];
  logic [3:0]         shadow_rank   [ENTRIES];

  out_item_t          pending_results[$];
  out_item_t          want;
  logic [FIELD_W-1:0] fill_src [ENTRIES];
  logic [FIELD_W-1:0] addr_pool [64];
  int                 pool_n;
  bit                 steady;
  int                 errors;
  int                 n_in;
  int                 n_out;

  branch_target_buffer_lru_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  // Move entry e to rank 0 and age every entry that was younger.
  function automatic void promote(input int e);
    logic [3:0] age;
    age = shadow_rank[e];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_rank[i] < age) begin
        shadow_rank[i] = shadow_rank[i] + 4'd1;
      end
    end
    shadow_rank[e] = 4'd0;
  endfunction

  function automatic out_item_t btb_predict(input in_item_t it);
    out_item_t r;
    int        found;
    int        victim;
    r = '0;
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_tag[i] == it.source_addr) begin
        found = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (it.cmd == CMD_LOOKUP) begin
        r.target_out = shadow_target[found];
      end
      promote(found);
    end else if (it.cmd == CMD_INSERT) begin
      victim = 0;
      for (int i = 1; i < ENTRIES; i++) begin
        if (shadow_rank[i] > shadow_rank[victim]) begin
          victim = i;
        end
      end
      shadow_tag[victim]    = it.source_addr;
      shadow_target[victim] = it.target_addr;
      shadow_valid[victim]  = 1'b1;
      promote(victim);
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] edge_addr();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 32'd1 << k;
      3: return ~(32'd1 << k);
      default: return $urandom;
    endcase
  endfunction

  // Drive one item and hold it until the transfer.
  task automatic send_item(input logic cmd, input logic [FIELD_W-1:0] src,
                           input logic [FIELD_W-1:0] tgt);
    in_item_t it;
    it.cmd = cmd;
    it.source_addr = src;
    it.target_addr = tgt;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom), $urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(btb_predict(it));
    n_in++;
  endtask

  // Hold off the sender until every expected result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_cold_lookup();
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Inserts fill entries in index order; then hit the extreme tags.
  task automatic test_fill();
    for (int i = 0; i < ENTRIES; i++) begin
      if (i == 0) fill_src[i] = 32'h0000_0000;
      else if (i == 1) fill_src[i] = 32'hFFFF_FFFF;
      else fill_src[i] = {4'(i), 28'(i * 32'h0123457)};
      send_item(CMD_INSERT, fill_src[i],
                (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0000_0000 : $urandom);
    end
    send_item(CMD_LOOKUP, fill_src[0], $urandom);
    send_item(CMD_LOOKUP, fill_src[1], $urandom);
  endtask

  // Reinsert keeps the old target; a new tag evicts the least recent entry.
  task automatic test_refresh_and_evict();
    send_item(CMD_INSERT, fill_src[2], 32'hDEAD_BEEF);
    send_item(CMD_LOOKUP, fill_src[2], 32'h0);
    send_item(CMD_INSERT, 32'h8765_4321, 32'h1234_5678);
    send_item(CMD_LOOKUP, fill_src[3], 32'h0);
  endtask

  task automatic run_mix(input int count, input int pool_size, input int insert_pct,
                         input bit pause_midway);
    logic               cmd;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] tgt;
    int                 r;
    pool_n = pool_size;
    for (int i = 0; i < pool_n; i++) begin
      addr_pool[i] = ($urandom_range(0, 9) == 0) ? edge_addr() : $urandom;
    end
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 85) src = addr_pool[$urandom_range(0, pool_n - 1)];
      else if (r < 93) src = addr_pool[$urandom_range(0, pool_n - 1)] ^
                             (32'd1 << $urandom_range(0, 31));
      else src = edge_addr();
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
      tgt = ($urandom_range(0, 7) == 0) ? edge_addr() : $urandom;
      send_item(cmd, src, tgt);
    end
  endtask

  task automatic test_working_set_hits();
    run_mix(480, 12, 30, 1'b0);
  endtask

  task automatic test_lru_thrash();
    run_mix(480, 20, 50, 1'b1);
  endtask

  task automatic test_sparse_tags();
    run_mix(480, 48, 60, 1'b0);
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_mix(480, 18, 40, 1'b0);
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", n_out));
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("result %0d hit got %0b want %0b",
                                    n_out, out_data.hit, want.hit));
        if (out_data.target_out !== want.target_out)
          report_mismatch($sformatf("result %0d target_out got %08h want %08h",
                                    n_out, out_data.target_out, want.target_out));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb_branch_target_buffer_lru_core failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    steady    = 1'b0;
    errors    = 0;
    n_in      = 0;
    n_out     = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 4'(ENTRIES - 1 - i);
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_cold_lookup();
    test_fill();
    test_refresh_and_evict();
    test_working_set_hits();
    test_lru_thrash();
    test_sparse_tags();
    test_steady_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("summary: %0d transfers in, %0d results checked", n_in, n_out);
    $display("summary: cold misses, fill order, refresh, eviction, random working sets");
    if (errors == 0) begin
      $display("tb_branch_target_buffer_lru_core passed");
    end else begin
      $display("tb_branch_target_buffer_lru_core failed");
    end
    $finish;
  end

endmodule
